FILE: hw/rtl/edq_pkg.sv
`timescale 1ns / 1ps

package edq_pkg;

  // input item kinds (tuser)
  localparam logic [1:0] KIND_CREATE   = 2'd0;
  localparam logic [1:0] KIND_COMPLETE = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  localparam logic [15:0] IDLE_SLEEP_RESET = 16'd100;
  localparam logic [31:0] SLEEP_RESET      = 32'd100;

  typedef struct packed {
    logic [31:0] rel_time;
    logic [31:0] deadline;
    logic [31:0] id;
  } entry_t;

endpackage

FILE: hw/rtl/edq_mem.sv
`timescale 1ns / 1ps

// Task table storage: one write port, one read port with registered data.
module edq_mem #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [IW-1:0]  waddr_i,
  input  edq_pkg::entry_t wdata_i,
  input  logic [IW-1:0]  raddr_i,
  output edq_pkg::entry_t rdata_o
);

  edq_pkg::entry_t mem_q [DEPTH];
  edq_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/edf_deadline_ready_queue.sv
`timescale 1ns / 1ps

// Channel   Group                      Payload
// --------  -------------------------  ------------------------------------------------
// input     s_axis_t{valid,ready,...}  tuser: kind; tdata: task_id, deadline, now_ticks
// output    m_axis_t{valid,ready,...}  tdata: status, head_valid, head_id, sleep_ticks,
//                                      removed_id, response_time, active_count
// config    cfg_we_i / cfg_wdata_i     idle_sleep_ticks
//
// One item at a time through a sequencer over the task table (one read, one write
// per cycle). Create shifts entries with later deadlines up from the tail until it
// finds its slot (no shifting into an empty or a full table); complete and timeout
// scan all active entries; both on an empty table, and unused kinds, go straight to
// the head read. Reset is asynchronous; the table needs no clearing. A finished
// result waits in the output register; the next item is accepted meanwhile, and the
// block stalls only when that register is still occupied.
module edf_deadline_ready_queue #(
  parameter int ACTIVE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] kind
  input  logic [1:0]  s_axis_tuser,
  // [31:0] task_id, [63:32] deadline, [95:64] now_ticks
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [2] head_valid, [34:3] head_id, [66:35] sleep_ticks,
  // [98:67] removed_id, [130:99] response_time, then active_count, zero pad
  output logic [((131 + $clog2(ACTIVE_DEPTH + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int IW    = $clog2(ACTIVE_DEPTH);
  localparam int CW    = $clog2(ACTIVE_DEPTH + 1);
  localparam int PAY_W = 131 + CW;
  localparam int OUT_W = ((PAY_W + 7) / 8) * 8;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_INS      = 3'd2;
  localparam logic [2:0] S_INS_HEAD = 3'd3;
  localparam logic [2:0] S_RMV      = 3'd4;
  localparam logic [2:0] S_HEAD     = 3'd5;
  localparam logic [2:0] S_RESULT   = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [IW-1:0] k_q, k_d;
  logic          found_q, found_d;
  logic [CW-1:0] count_q, count_d;
  logic [31:0]   sleep_q, sleep_d;
  logic [15:0]   idle_q, idle_d;
  logic          out_valid_q, out_valid_d;
  logic [PAY_W-1:0] out_q, out_d;

  logic [1:0]  kind_q, kind_d;
  logic [31:0] id_q, id_d;
  logic [31:0] dl_q, dl_d;
  logic [31:0] now_q, now_d;
  logic [1:0]  status_q, status_d;
  logic [31:0] removed_q, removed_d;
  logic [31:0] resp_q, resp_d;

  logic            we;
  logic [IW-1:0]   waddr;
  logic [IW-1:0]   raddr;
  edq_pkg::entry_t wdata;
  edq_pkg::entry_t rd_data;
  edq_pkg::entry_t new_entry;
  logic            last;
  logic            match;
  logic [31:0]     head_id;

  edq_mem #(
    .DEPTH (ACTIVE_DEPTH),
    .IW    (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  assign new_entry = '{rel_time: now_q, deadline: dl_q, id: id_q};
  assign last      = (CW'(k_q) == count_q - CW'(1));
  // timeout evicts the head; complete looks for the first id match
  assign match     = (kind_q == edq_pkg::KIND_TIMEOUT) ? (k_q == '0) : (rd_data.id == id_q);
  assign head_id   = (count_q != '0) ? rd_data.id : 32'd0;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'(out_q);

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    found_d     = found_q;
    count_d     = count_q;
    sleep_d     = sleep_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    kind_d      = kind_q;
    id_d        = id_q;
    dl_d        = dl_q;
    now_d       = now_q;
    status_d    = status_q;
    removed_d   = removed_q;
    resp_d      = resp_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = rd_data;
    raddr       = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          kind_d    = s_axis_tuser;
          id_d      = s_axis_tdata[31:0];
          dl_d      = s_axis_tdata[63:32];
          now_d     = s_axis_tdata[95:64];
          status_d  = edq_pkg::ST_OK;
          removed_d = 32'd0;
          resp_d    = 32'd0;
          found_d   = 1'b0;
          state_d   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (kind_q)
          edq_pkg::KIND_CREATE: begin
            if (count_q == CW'(ACTIVE_DEPTH)) begin
              status_d = edq_pkg::ST_FULL;
              state_d  = S_HEAD;
            end else if (count_q == '0) begin
              we      = 1'b1;
              wdata   = new_entry;
              count_d = count_q + CW'(1);
              state_d = S_HEAD;
            end else begin
              // walk down from the tail, shifting later deadlines up
              raddr   = IW'(count_q - CW'(1));
              k_d     = IW'(count_q - CW'(1));
              state_d = S_INS;
            end
          end
          edq_pkg::KIND_COMPLETE, edq_pkg::KIND_TIMEOUT: begin
            if (count_q == '0) begin
              if (kind_q == edq_pkg::KIND_TIMEOUT) begin
                status_d = edq_pkg::ST_EMPTY;
                sleep_d  = {16'd0, idle_q};
              end else begin
                status_d = edq_pkg::ST_NOT_FOUND;
              end
              state_d = S_HEAD;
            end else begin
              k_d     = '0;
              state_d = S_RMV;
            end
          end
          default: state_d = S_HEAD;
        endcase
      end
      S_INS: begin
        if (rd_data.deadline > dl_q) begin
          we    = 1'b1;
          waddr = k_q + IW'(1);
          wdata = rd_data;
          if (k_q == '0) begin
            state_d = S_INS_HEAD;
          end else begin
            raddr = k_q - IW'(1);
            k_d   = k_q - IW'(1);
          end
        end else begin
          we      = 1'b1;
          waddr   = k_q + IW'(1);
          wdata   = new_entry;
          count_d = count_q + CW'(1);
          state_d = S_HEAD;
        end
      end
      S_INS_HEAD: begin
        we      = 1'b1;
        wdata   = new_entry;
        count_d = count_q + CW'(1);
        state_d = S_HEAD;
      end
      S_RMV: begin
        if (!last) begin
          raddr = k_q + IW'(1);
          k_d   = k_q + IW'(1);
        end
        if (found_q) begin
          // close the gap behind the removed entry
          we    = 1'b1;
          waddr = k_q - IW'(1);
          wdata = rd_data;
        end else if (match) begin
          found_d   = 1'b1;
          removed_d = rd_data.id;
          // an overdue eviction reports no response time
          if (kind_q == edq_pkg::KIND_COMPLETE) begin
            resp_d = now_q - rd_data.rel_time;
          end
        end
        if (last) begin
          if (found_q || match) begin
            count_d = count_q - CW'(1);
          end else begin
            status_d = edq_pkg::ST_NOT_FOUND;
          end
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (count_q != '0) begin
          sleep_d = rd_data.deadline - now_q;
        end
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_d       = {count_q, resp_q, removed_q, sleep_d, head_id,
                         (count_q != '0), status_q};
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    idle_d = idle_q;
    if (cfg_we_i) begin
      idle_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      found_q     <= 1'b0;
      count_q     <= '0;
      sleep_q     <= edq_pkg::SLEEP_RESET;
      idle_q      <= edq_pkg::IDLE_SLEEP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      found_q     <= found_d;
      count_q     <= count_d;
      sleep_q     <= sleep_d;
      idle_q      <= idle_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q     <= out_d;
    kind_q    <= kind_d;
    id_q      <= id_d;
    dl_q      <= dl_d;
    now_q     <= now_d;
    status_q  <= status_d;
    removed_q <= removed_d;
    resp_q    <= resp_d;
  end

endmodule

FILE: tb/edf_deadline_ready_queue_tb.sv
`timescale 1ns / 1ps

module edf_deadline_ready_queue_tb;

  localparam int DEPTH        = 16;
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int OUT_W        = ((131 + CNT_W + 7) / 8) * 8;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 600000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] id;
    logic [31:0] dl;
    logic [31:0] now;
  } sched_event_t;

  typedef struct {
    logic [1:0]       status;
    logic             head_valid;
    logic [31:0]      head_id;
    logic [31:0]      sleep;
    logic [31:0]      removed;
    logic [31:0]      resp;
    logic [CNT_W-1:0] count;
  } sched_result_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic [15:0]      cfg_wdata_i   = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [1:0]       s_axis_tuser  = '0;
  logic [95:0]      s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  edf_deadline_ready_queue #(
    .ACTIVE_DEPTH(DEPTH)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser(s_axis_tuser),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow of the task table
  edq_pkg::entry_t tbl [DEPTH];
  int              tbl_count = 0;
  logic [31:0]     sleep_val = edq_pkg::SLEEP_RESET;
  logic [15:0]     idle_cfg  = edq_pkg::IDLE_SLEEP_RESET;

  sched_event_t  event_q[$];
  sched_result_t results_q[$];
  logic [31:0]   live_ids[$];
  logic [31:0]   gen_now = '0;

  int src_idle_pct = 0;
  int rcv_idle_pct = 0;
  int err_count    = 0;
  int n_accepted   = 0;
  int n_checked    = 0;
  int n_full       = 0;
  int n_empty      = 0;
  int n_not_found  = 0;
  int cycle_count  = 0;

  function automatic void drop_entry(int pos);
    int k;
    for (k = pos; k + 1 < tbl_count; k++) tbl[k] = tbl[k + 1];
    tbl_count--;
  endfunction

  function automatic sched_result_t edf_table_step(logic [1:0] kind, logic [31:0] id,
                                                   logic [31:0] dl, logic [31:0] now);
    sched_result_t r;
    int pos;
    int k;
    r = '{default: '0};
    r.status = edq_pkg::ST_OK;
    case (kind)
      edq_pkg::KIND_CREATE: begin
        if (tbl_count >= DEPTH) begin
          r.status = edq_pkg::ST_FULL;
        end else begin
          // equal deadlines queue behind existing ones
          pos = 0;
          while (pos < tbl_count && tbl[pos].deadline <= dl) pos++;
          for (k = tbl_count; k > pos; k--) tbl[k] = tbl[k - 1];
          tbl[pos].id       = id;
          tbl[pos].deadline = dl;
          tbl[pos].rel_time = now;
          tbl_count++;
        end
      end
      edq_pkg::KIND_COMPLETE: begin
        pos = 0;
        while (pos < tbl_count && tbl[pos].id != id) pos++;
        if (pos >= tbl_count) begin
          r.status = edq_pkg::ST_NOT_FOUND;
        end else begin
          r.removed = tbl[pos].id;
          r.resp    = now - tbl[pos].rel_time;
          drop_entry(pos);
        end
      end
      edq_pkg::KIND_TIMEOUT: begin
        if (tbl_count == 0) begin
          sleep_val = {16'h0000, idle_cfg};
          r.status  = edq_pkg::ST_EMPTY;
        end else begin
          r.removed = tbl[0].id;
          drop_entry(0);
        end
      end
      default: ;
    endcase
    if (tbl_count > 0) sleep_val = tbl[0].deadline - now;
    r.head_valid = (tbl_count > 0);
    r.head_id    = (tbl_count > 0) ? tbl[0].id : 32'h0;
    r.sleep      = sleep_val;
    r.count      = tbl_count[CNT_W-1:0];
    return r;
  endfunction

  // driver: one item in flight on the input side
  always @(posedge clk_i) begin
    sched_event_t ev;
    sched_result_t r;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        r = edf_table_step(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32],
                           s_axis_tdata[95:64]);
        results_q.push_back(r);
        n_accepted++;
        if (r.status == edq_pkg::ST_FULL) n_full++;
        if (r.status == edq_pkg::ST_EMPTY) n_empty++;
        if (r.status == edq_pkg::ST_NOT_FOUND) n_not_found++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (event_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          ev = event_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= ev.kind;
          s_axis_tdata  <= {ev.now, ev.dl, ev.id};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic cmp_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      err_count++;
    end
  endtask

  // monitor
  always @(posedge clk_i) begin
    sched_result_t e;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (results_q.size() == 0) begin
          $error("result with nothing expected: tdata %0h", m_axis_tdata);
          err_count++;
        end else begin
          e = results_q.pop_front();
          n_checked++;
          cmp_field("status", 32'(e.status), 32'(m_axis_tdata[1:0]));
          cmp_field("head_valid", 32'(e.head_valid), 32'(m_axis_tdata[2]));
          cmp_field("head_id", e.head_id, m_axis_tdata[34:3]);
          cmp_field("sleep_ticks", e.sleep, m_axis_tdata[66:35]);
          cmp_field("removed_id", e.removed, m_axis_tdata[98:67]);
          cmp_field("response_time", e.resp, m_axis_tdata[130:99]);
          cmp_field("active_count", 32'(e.count), 32'(m_axis_tdata[131 +: CNT_W]));
        end
      end
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic push_event(logic [1:0] kind, logic [31:0] id, logic [31:0] dl,
                            logic [31:0] now);
    sched_event_t ev;
    ev.kind = kind;
    ev.id   = id;
    ev.dl   = dl;
    ev.now  = now;
    event_q.push_back(ev);
  endtask

  task automatic push_random_event(int create_pct);
    logic [31:0] id;
    logic [31:0] dl;
    int r;
    int idx;
    gen_now += $urandom_range(0, 50);
    if ($urandom_range(99) < 3) gen_now = $urandom;
    id = $urandom;
    dl = $urandom;
    r  = $urandom_range(99);
    if (r < create_pct) begin
      if ($urandom_range(99) < 20) id = $urandom_range(0, 7);
      case ($urandom_range(9))
        0, 1:    dl = $urandom;
        2, 3:    dl = gen_now + $urandom_range(0, 8);  // frequent ties
        default: dl = gen_now + $urandom_range(0, 400);
      endcase
      live_ids.push_back(id);
      if (live_ids.size() > 40) void'(live_ids.pop_front());
      push_event(edq_pkg::KIND_CREATE, id, dl, gen_now);
    end else begin
      r = $urandom_range(99);
      if (r < 60 && live_ids.size() > 0) begin
        idx = $urandom_range(0, live_ids.size() - 1);
        id  = live_ids[idx];
        live_ids.delete(idx);
        push_event(edq_pkg::KIND_COMPLETE, id, dl, gen_now);
      end else if (r < 70) begin
        push_event(edq_pkg::KIND_COMPLETE, id, dl, gen_now);
      end else if (r < 92) begin
        push_event(edq_pkg::KIND_TIMEOUT, id, dl, gen_now);
      end else begin
        push_event(KIND_UNUSED, id, dl, gen_now);
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (event_q.size() > 0 || s_axis_tvalid || results_q.size() > 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_idle_sleep(logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    idle_cfg = value;
  endtask

  initial begin
    int p;
    int i;
    int src_pct [4];
    int rcv_pct [4];
    int create_pct [PHASES];
    logic [15:0] idle_vals [PHASES];
    src_pct    = '{0, 51, 0, 34};
    rcv_pct    = '{0, 0, 51, 34};
    create_pct = '{50, 70, 35, 55, 72, 45};
    idle_vals  = '{16'hFFFF, 16'h0000, 16'h0001, 16'($urandom), 16'd100, 16'($urandom)};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty-table cases with the reset idle value
    push_event(edq_pkg::KIND_TIMEOUT, 32'h0, 32'h0, 32'h0);
    push_event(edq_pkg::KIND_COMPLETE, 32'd5, 32'h0, 32'h0);
    push_event(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // field extremes, new head, sleep wrap
    push_event(edq_pkg::KIND_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    push_event(edq_pkg::KIND_CREATE, 32'h0, 32'h0, 32'hFFFF_FFFF);
    // equal deadlines, duplicate id landing earlier
    push_event(edq_pkg::KIND_CREATE, 32'd7, 32'd1000, 32'd10);
    push_event(edq_pkg::KIND_CREATE, 32'd8, 32'd1000, 32'd11);
    push_event(edq_pkg::KIND_CREATE, 32'd7, 32'd500, 32'd12);
    push_event(edq_pkg::KIND_COMPLETE, 32'd7, 32'h0, 32'd20);
    push_event(edq_pkg::KIND_COMPLETE, 32'd12345, 32'h0, 32'd25);
    push_event(KIND_UNUSED, 32'h0, 32'h0, 32'd30);
    push_event(edq_pkg::KIND_TIMEOUT, 32'h0, 32'h0, 32'd40);
    // fill the table, then one create past capacity
    for (i = 0; i < 14; i++) begin
      push_event(edq_pkg::KIND_CREATE, 32'd100 + i, 32'd2000 + 3 * i, 32'd50);
    end
    push_event(edq_pkg::KIND_COMPLETE, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    wait_drained();

    for (p = 0; p < PHASES; p++) begin
      write_idle_sleep(idle_vals[p]);
      @(negedge clk_i);
      src_idle_pct = src_pct[p % 4];
      rcv_idle_pct = rcv_pct[p % 4];
      for (i = 0; i < PHASE_ITEMS; i++) push_random_event(create_pct[p]);
      wait_drained();
    end

    if (results_q.size() > 0) begin
      $error("%0d results never arrived", results_q.size());
      err_count++;
    end
    $display("Covered %0d items over %0d phases with idle sleep from 0 to 65535 and mixed stalls",
             n_accepted, PHASES);
    $display("Checked %0d results: %0d full, %0d empty, %0d not found",
             n_checked, n_full, n_empty, n_not_found);
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
